@@ rtl/ffha_pkg.sv @@
package ffha_pkg;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_NOMEM = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_A_RD,
    ST_A_CHK,
    ST_D_RD,
    ST_D_WR,
    ST_F_RD,
    ST_F_CHK,
    ST_U_RD,
    ST_U_WR,
    ST_J_GUARD,
    ST_J_RD1,
    ST_J_CHK,
    ST_J_NEXT,
    ST_S_INIT,
    ST_SUM,
    ST_DONE
  } state_t;

endpackage

@@ rtl/first_fit_hole_allocator.sv @@
// Channel  Handshake            Payload
// in       start / busy         in_opcode, in_free_base, in_request_length
// out      out_valid (strobe)   out_alloc_base, out_status, out_largest_hole, out_total_free
//
// One operation at a time. An allocate scans the holes in order and, when a used-up
// hole is dropped, moves every later hole down. A free passes holes while searching
// and moves later holes to open a slot, plus up to two joins, each of which may move
// up to every later hole. Every operation ends with a summary pass over all holes.
// Reset empties the table at once. Results cannot be stalled.
module first_fit_hole_allocator #(
  parameter int HOLE_SLOTS = 128,
  parameter int CLICK_BITS = 20
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_opcode,
  input  logic [CLICK_BITS-1:0] in_free_base,
  input  logic [CLICK_BITS-1:0] in_request_length,
  output logic                  out_valid,
  output logic [CLICK_BITS-1:0] out_alloc_base,
  output logic [1:0]            out_status,
  output logic [CLICK_BITS:0]   out_largest_hole,
  output logic [CLICK_BITS:0]   out_total_free
);

  localparam int AW = (HOLE_SLOTS > 1) ? $clog2(HOLE_SLOTS) : 1;
  localparam int CW = $clog2(HOLE_SLOTS + 1);
  localparam int LW = CLICK_BITS + 1;
  localparam logic [LW-1:0] LEN_CAP = LW'(1) << CLICK_BITS;

  logic [CLICK_BITS-1:0] base_mem [HOLE_SLOTS];
  logic [LW-1:0]         len_mem  [HOLE_SLOTS];

  ffha_pkg::state_t state_r, state_nxt, ret_r, ret_nxt;
  logic                  op_r, op_nxt;
  logic [CLICK_BITS-1:0] base_r, base_nxt, req_r, req_nxt, got_r, got_nxt;
  logic [CLICK_BITS-1:0] hb_r, hb_nxt;
  logic [LW-1:0]         hl_r, hl_nxt, max_r, max_nxt, tot_r, tot_nxt;
  logic [CW-1:0]         idx_r, idx_nxt, p_r, p_nxt, cnt_r, cnt_nxt;
  logic                  phase_r, phase_nxt, joined_r, joined_nxt, sv_r, sv_nxt;
  logic [1:0]            status_r, status_nxt;

  logic [CLICK_BITS-1:0] rd_base_r;
  logic [LW-1:0]         rd_len_r;
  logic [AW-1:0]         mem_ra, mem_wa;
  logic                  mem_we;
  logic [CLICK_BITS-1:0] mem_wbase;
  logic [LW-1:0]         mem_wlen;

  logic                  fit, exact, adj, gt, idx_lt_cnt;
  logic [CW-1:0]         idx_inc, idx_dec, p_inc;
  logic [LW:0]           join_sum, tot_sum;
  logic [LW-1:0]         join_len;

  assign fit        = rd_len_r >= {1'b0, req_r};
  assign exact      = rd_len_r == {1'b0, req_r};
  assign gt         = base_r > rd_base_r;
  assign adj        = ({2'b00, hb_r} + {1'b0, hl_r}) == {2'b00, rd_base_r};
  assign idx_inc    = idx_r + 1'b1;
  assign idx_dec    = idx_r - 1'b1;
  assign p_inc      = p_r + 1'b1;
  assign idx_lt_cnt = idx_r < cnt_r;
  assign join_sum   = {1'b0, hl_r} + {1'b0, rd_len_r};
  assign join_len   = (join_sum > {1'b0, LEN_CAP}) ? LEN_CAP : join_sum[LW-1:0];
  assign tot_sum    = {1'b0, tot_r} + {1'b0, rd_len_r};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      base_mem[mem_wa] <= mem_wbase;
      len_mem[mem_wa]  <= mem_wlen;
    end
    rd_base_r <= base_mem[mem_ra];
    rd_len_r  <= len_mem[mem_ra];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ffha_pkg::ST_IDLE: begin
        if (start) begin
          if (in_opcode == ffha_pkg::OP_ALLOC) begin
            state_nxt = (cnt_r == '0) ? ffha_pkg::ST_S_INIT : ffha_pkg::ST_A_RD;
          end else if (in_request_length == '0 || cnt_r >= CW'(HOLE_SLOTS)) begin
            state_nxt = ffha_pkg::ST_S_INIT;
          end else begin
            state_nxt = ffha_pkg::ST_F_RD;
          end
        end
      end
      ffha_pkg::ST_A_RD:  state_nxt = ffha_pkg::ST_A_CHK;
      ffha_pkg::ST_A_CHK: begin
        if (fit) begin
          state_nxt = exact ? ffha_pkg::ST_D_RD : ffha_pkg::ST_S_INIT;
        end else begin
          state_nxt = (idx_inc == cnt_r) ? ffha_pkg::ST_S_INIT : ffha_pkg::ST_A_RD;
        end
      end
      ffha_pkg::ST_D_RD:  state_nxt = (idx_inc < cnt_r) ? ffha_pkg::ST_D_WR : ret_r;
      ffha_pkg::ST_D_WR:  state_nxt = ffha_pkg::ST_D_RD;
      ffha_pkg::ST_F_RD:  state_nxt = idx_lt_cnt ? ffha_pkg::ST_F_CHK : ffha_pkg::ST_U_RD;
      ffha_pkg::ST_F_CHK: state_nxt = gt ? ffha_pkg::ST_F_RD : ffha_pkg::ST_U_RD;
      ffha_pkg::ST_U_RD:  state_nxt = (idx_r > p_r) ? ffha_pkg::ST_U_WR : ffha_pkg::ST_J_GUARD;
      ffha_pkg::ST_U_WR:  state_nxt = ffha_pkg::ST_U_RD;
      ffha_pkg::ST_J_GUARD: begin
        state_nxt = (p_inc < cnt_r) ? ffha_pkg::ST_J_RD1 : ffha_pkg::ST_S_INIT;
      end
      ffha_pkg::ST_J_RD1: state_nxt = ffha_pkg::ST_J_CHK;
      ffha_pkg::ST_J_CHK: state_nxt = adj ? ffha_pkg::ST_D_RD : ffha_pkg::ST_J_NEXT;
      ffha_pkg::ST_J_NEXT: begin
        state_nxt = phase_r ? ffha_pkg::ST_S_INIT : ffha_pkg::ST_J_GUARD;
      end
      ffha_pkg::ST_S_INIT: state_nxt = ffha_pkg::ST_SUM;
      ffha_pkg::ST_SUM: begin
        if (!idx_lt_cnt && !sv_r) begin
          state_nxt = ffha_pkg::ST_DONE;
        end
      end
      ffha_pkg::ST_DONE:  state_nxt = ffha_pkg::ST_IDLE;
      default:            state_nxt = ffha_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ret_nxt    = ret_r;
    op_nxt     = op_r;
    base_nxt   = base_r;
    req_nxt    = req_r;
    got_nxt    = got_r;
    hb_nxt     = hb_r;
    hl_nxt     = hl_r;
    max_nxt    = max_r;
    tot_nxt    = tot_r;
    idx_nxt    = idx_r;
    p_nxt      = p_r;
    cnt_nxt    = cnt_r;
    phase_nxt  = phase_r;
    joined_nxt = joined_r;
    sv_nxt     = sv_r;
    status_nxt = status_r;
    mem_ra     = idx_r[AW-1:0];
    mem_we     = 1'b0;
    mem_wa     = idx_r[AW-1:0];
    mem_wbase  = rd_base_r;
    mem_wlen   = rd_len_r;
    case (state_r)
      ffha_pkg::ST_IDLE: begin
        if (start) begin
          op_nxt  = in_opcode;
          base_nxt = in_free_base;
          req_nxt = in_request_length;
          got_nxt = '0;
          idx_nxt = '0;
          if (in_opcode == ffha_pkg::OP_ALLOC) begin
            status_nxt = ffha_pkg::STAT_NOMEM;
          end else if (in_request_length != '0 && cnt_r >= CW'(HOLE_SLOTS)) begin
            status_nxt = ffha_pkg::STAT_FULL;
          end else begin
            status_nxt = ffha_pkg::STAT_OK;
          end
        end
      end
      ffha_pkg::ST_A_CHK: begin
        if (fit) begin
          got_nxt    = rd_base_r;
          status_nxt = ffha_pkg::STAT_OK;
          ret_nxt    = ffha_pkg::ST_S_INIT;
          if (!exact) begin
            mem_we    = 1'b1;
            mem_wbase = rd_base_r + req_r;
            mem_wlen  = rd_len_r - {1'b0, req_r};
          end
        end else begin
          idx_nxt = idx_inc;
        end
      end
      ffha_pkg::ST_D_RD: begin
        if (idx_inc < cnt_r) begin
          mem_ra = idx_inc[AW-1:0];
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ffha_pkg::ST_D_WR: begin
        mem_we  = 1'b1;
        idx_nxt = idx_inc;
      end
      ffha_pkg::ST_F_RD: begin
        if (!idx_lt_cnt) begin
          p_nxt   = idx_r;
          idx_nxt = cnt_r;
        end
      end
      ffha_pkg::ST_F_CHK: begin
        if (gt) begin
          idx_nxt = idx_inc;
        end else begin
          p_nxt   = idx_r;
          idx_nxt = cnt_r;
        end
      end
      ffha_pkg::ST_U_RD: begin
        if (idx_r > p_r) begin
          mem_ra = idx_dec[AW-1:0];
        end else begin
          mem_we    = 1'b1;
          mem_wa    = p_r[AW-1:0];
          mem_wbase = base_r;
          mem_wlen  = {1'b0, req_r};
          cnt_nxt   = cnt_r + 1'b1;
          p_nxt     = (p_r == '0) ? '0 : p_r - 1'b1;
          phase_nxt = 1'b0;
        end
      end
      ffha_pkg::ST_U_WR: begin
        mem_we  = 1'b1;
        idx_nxt = idx_dec;
      end
      ffha_pkg::ST_J_GUARD: mem_ra = p_r[AW-1:0];
      ffha_pkg::ST_J_RD1: begin
        hb_nxt = rd_base_r;
        hl_nxt = rd_len_r;
        mem_ra = p_inc[AW-1:0];
      end
      ffha_pkg::ST_J_CHK: begin
        joined_nxt = adj;
        if (adj) begin
          mem_we    = 1'b1;
          mem_wa    = p_r[AW-1:0];
          mem_wbase = hb_r;
          mem_wlen  = join_len;
          idx_nxt   = p_inc;
          ret_nxt   = ffha_pkg::ST_J_NEXT;
        end
      end
      ffha_pkg::ST_J_NEXT: begin
        if (!phase_r) begin
          phase_nxt = 1'b1;
          if (!joined_r) begin
            p_nxt = p_inc;
          end
        end
      end
      ffha_pkg::ST_S_INIT: begin
        idx_nxt = '0;
        sv_nxt  = 1'b0;
        max_nxt = '0;
        tot_nxt = '0;
      end
      ffha_pkg::ST_SUM: begin
        sv_nxt = idx_lt_cnt;
        if (idx_lt_cnt) begin
          idx_nxt = idx_inc;
        end
        if (sv_r) begin
          if (rd_len_r > max_r) begin
            max_nxt = rd_len_r;
          end
          tot_nxt = (tot_sum > {1'b0, LEN_CAP}) ? LEN_CAP : tot_sum[LW-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ffha_pkg::ST_IDLE;
      ret_r   <= ffha_pkg::ST_S_INIT;
      cnt_r   <= '0;
      tot_r   <= '0;
      max_r   <= '0;
      sv_r    <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      cnt_r   <= cnt_nxt;
      tot_r   <= tot_nxt;
      max_r   <= max_nxt;
      sv_r    <= sv_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    base_r   <= base_nxt;
    req_r    <= req_nxt;
    got_r    <= got_nxt;
    hb_r     <= hb_nxt;
    hl_r     <= hl_nxt;
    idx_r    <= idx_nxt;
    p_r      <= p_nxt;
    joined_r <= joined_nxt;
    status_r <= status_nxt;
  end

  always_comb begin
    busy             = state_r != ffha_pkg::ST_IDLE;
    out_valid        = state_r == ffha_pkg::ST_DONE;
    out_status       = status_r;
    out_alloc_base   = (status_r == ffha_pkg::STAT_OK && op_r == ffha_pkg::OP_ALLOC) ?
                       got_r : '0;
    out_largest_hole = max_r;
    out_total_free   = tot_r;
  end

endmodule

@@ rtl/ffha_checker.sv @@
module ffha_checker #(
  parameter int CLICK_BITS = 20
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input logic                  out_valid,
  input logic [CLICK_BITS-1:0] out_alloc_base,
  input logic [1:0]            out_status,
  input logic [CLICK_BITS:0]   out_largest_hole,
  input logic [CLICK_BITS:0]   out_total_free
);

  // An accepted beat raises busy; the block then stays busy until its result has been shown.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted beat did not raise busy");

  a_strobe_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy && !out_valid)
    else $error("result strobe not followed by idle");

  a_fail_base_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ffha_pkg::STAT_OK |-> out_alloc_base == '0)
    else $error("failed operation returned a base");

  a_largest_le_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_largest_hole <= out_total_free)
    else $error("largest hole exceeds total free space");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == ffha_pkg::STAT_OK || out_status == ffha_pkg::STAT_NOMEM ||
                  out_status == ffha_pkg::STAT_FULL)
    else $error("undefined status code");

endmodule

bind first_fit_hole_allocator ffha_checker #(.CLICK_BITS(CLICK_BITS)) u_ffha_checker (.*);

@@ tb/sv/first_fit_hole_allocator_tb.sv @@
module first_fit_hole_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 128;
  localparam int CBITS = 20;
  localparam logic [20:0] LEN_CAP = 21'h100000;
  localparam int CYCLE_LIMIT = 4000000;

  typedef struct {
    logic [19:0] alloc_base;
    logic [1:0]  status;
    logic [20:0] largest_hole;
    logic [20:0] total_free;
  } alloc_result_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_opcode;
  logic [19:0] in_free_base;
  logic [19:0] in_request_length;
  logic        out_valid;
  logic [19:0] out_alloc_base;
  logic [1:0]  out_status;
  logic [20:0] out_largest_hole;
  logic [20:0] out_total_free;

  logic [19:0] hole_base[SLOTS];
  logic [20:0] hole_len[SLOTS];
  int          hole_count;

  alloc_result_t pending_results[$];
  int mismatches = 0;
  int cycles = 0;
  int burst_left;

  first_fit_hole_allocator #(.HOLE_SLOTS(SLOTS), .CLICK_BITS(CBITS)) u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_opcode(in_opcode), .in_free_base(in_free_base),
    .in_request_length(in_request_length), .out_valid(out_valid),
    .out_alloc_base(out_alloc_base), .out_status(out_status),
    .out_largest_hole(out_largest_hole), .out_total_free(out_total_free)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void drop_hole(int idx);
    for (int k = idx; k + 1 < hole_count; k++) begin
      hole_base[k] = hole_base[k + 1];
      hole_len[k] = hole_len[k + 1];
    end
    hole_count--;
  endfunction

  function automatic bit join_next(int p);
    logic [21:0] sum;
    if (p + 1 >= hole_count) return 1'b0;
    if ({2'b00, hole_base[p]} + hole_len[p] != {2'b00, hole_base[p + 1]}) return 1'b0;
    sum = hole_len[p] + hole_len[p + 1];
    hole_len[p] = (sum > LEN_CAP) ? LEN_CAP : sum[20:0];
    drop_hole(p + 1);
    return 1'b1;
  endfunction

  function automatic alloc_result_t apply_op(logic op, logic [19:0] base, logic [19:0] len);
    alloc_result_t r;
    logic [19:0] got;
    logic [21:0] tot;
    int pos;
    int p;
    got = '0;
    r.status = ffha_pkg::STAT_OK;
    if (op == ffha_pkg::OP_ALLOC) begin
      r.status = ffha_pkg::STAT_NOMEM;
      for (int k = 0; k < hole_count; k++) begin
        if (hole_len[k] >= {1'b0, len}) begin
          got = hole_base[k];
          hole_base[k] = hole_base[k] + len;
          hole_len[k] = hole_len[k] - len;
          if (hole_len[k] == 0) drop_hole(k);
          r.status = ffha_pkg::STAT_OK;
          break;
        end
      end
    end else if (len != 0) begin
      if (hole_count >= SLOTS) begin
        r.status = ffha_pkg::STAT_FULL;
      end else begin
        pos = 0;
        while (pos < hole_count && base > hole_base[pos]) pos++;
        for (int k = hole_count; k > pos; k--) begin
          hole_base[k] = hole_base[k - 1];
          hole_len[k] = hole_len[k - 1];
        end
        hole_base[pos] = base;
        hole_len[pos] = {1'b0, len};
        hole_count++;
        p = (pos == 0) ? 0 : pos - 1;
        if (p + 1 < hole_count) begin
          if (!join_next(p)) p++;
          void'(join_next(p));
        end
      end
    end
    r.largest_hole = '0;
    tot = '0;
    for (int k = 0; k < hole_count; k++) begin
      if (hole_len[k] > r.largest_hole) r.largest_hole = hole_len[k];
      tot = tot + hole_len[k];
      if (tot > LEN_CAP) tot = LEN_CAP;
    end
    r.total_free = tot[20:0];
    r.alloc_base = (r.status == ffha_pkg::STAT_OK && op == ffha_pkg::OP_ALLOC) ? got : '0;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    alloc_result_t e;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        e = pending_results.pop_front();
        if (out_alloc_base !== e.alloc_base)
          report_mismatch($sformatf("alloc_base %h exp %h", out_alloc_base, e.alloc_base));
        if (out_status !== e.status)
          report_mismatch($sformatf("status %0d exp %0d", out_status, e.status));
        if (out_largest_hole !== e.largest_hole)
          report_mismatch($sformatf("largest_hole %h exp %h", out_largest_hole,
                                    e.largest_hole));
        if (out_total_free !== e.total_free)
          report_mismatch($sformatf("total_free %h exp %h", out_total_free, e.total_free));
      end
    end
  end

  task automatic send_op(logic op, logic [19:0] base, logic [19:0] len);
    if (burst_left == 0) begin
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 10);
    end
    burst_left--;
    start <= 1'b1;
    in_opcode <= op;
    in_free_base <= base;
    in_request_length <= len;
    do @(posedge clk); while (busy);
    pending_results.push_back(apply_op(op, base, len));
  endtask

  task automatic test_directed();
    send_op(ffha_pkg::OP_ALLOC, 20'd5, 20'd5);
    send_op(ffha_pkg::OP_ALLOC, 20'hFFFFF, 20'd0);
    send_op(ffha_pkg::OP_FREE, 20'd100, 20'd0);
    send_op(ffha_pkg::OP_FREE, 20'hFFFFF, 20'hFFFFF);
    send_op(ffha_pkg::OP_ALLOC, 20'd0, 20'h10);
    send_op(ffha_pkg::OP_FREE, 20'd0, 20'hFFFFF);
    send_op(ffha_pkg::OP_FREE, 20'hFFFFF, 20'hFFFFF);
    send_op(ffha_pkg::OP_ALLOC, 20'd0, 20'd0);
    send_op(ffha_pkg::OP_ALLOC, 20'd0, 20'hFFFFF);
    send_op(ffha_pkg::OP_ALLOC, 20'd0, 20'hFFFFF);
    send_op(ffha_pkg::OP_FREE, 20'd200, 20'd50);
    send_op(ffha_pkg::OP_FREE, 20'd300, 20'd50);
    send_op(ffha_pkg::OP_FREE, 20'd250, 20'd50);
    send_op(ffha_pkg::OP_FREE, 20'd100, 20'd100);
    send_op(ffha_pkg::OP_FREE, 20'd10, 20'd5);
    send_op(ffha_pkg::OP_FREE, 20'd15, 20'd5);
    send_op(ffha_pkg::OP_ALLOC, 20'hAAAAA, 20'd5);
    send_op(ffha_pkg::OP_ALLOC, 20'd0, 20'hFFFFF);
    send_op(ffha_pkg::OP_FREE, 20'h55555, 20'hAAAAA);
    send_op(ffha_pkg::OP_ALLOC, 20'h0, 20'd250);
  endtask

  task automatic test_table_full();
    int i;
    i = 0;
    while (hole_count < SLOTS) begin
      send_op(ffha_pkg::OP_FREE, 20'h80000 + 20'(i * 4), 20'd1);
      i++;
    end
    send_op(ffha_pkg::OP_FREE, 20'h80001, 20'd3);
    send_op(ffha_pkg::OP_FREE, 20'h7FFFF, 20'd1);
    send_op(ffha_pkg::OP_FREE, 20'h80001, 20'd0);
    send_op(ffha_pkg::OP_ALLOC, 20'd0, 20'd1);
    send_op(ffha_pkg::OP_FREE, 20'hC0000, 20'd7);
    send_op(ffha_pkg::OP_FREE, 20'hC0007, 20'd7);
  endtask

  task automatic test_random(int count);
    int sel;
    int k;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
        send_op(1'($urandom), 20'($urandom), 20'($urandom));
      end else if (sel <= 4) begin
        send_op(ffha_pkg::OP_FREE, 20'($urandom_range(0, 4095)), 20'($urandom_range(1, 64)));
      end else if (sel <= 8 || hole_count == 0) begin
        send_op(ffha_pkg::OP_ALLOC, 20'($urandom), 20'($urandom_range(0, 80)));
      end else begin
        k = $urandom_range(0, hole_count - 1);
        send_op(ffha_pkg::OP_FREE, 20'(hole_base[k] + hole_len[k]),
                20'($urandom_range(1, 32)));
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_opcode = ffha_pkg::OP_ALLOC;
    in_free_base = '0;
    in_request_length = '0;
    burst_left = 0;
    hole_count = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_table_full();
    test_random(250);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
